// ----- rtl/wre_pkg.sv -----
// Shared types and constants for the withdrawal RLP encoder.
package wre_pkg;

    // RLP prefix bytes.
    localparam logic [7:0] RLP_SHORT_STR  = 8'h80;
    localparam logic [7:0] RLP_SHORT_LIST = 8'hc0;
    localparam logic [7:0] RLP_ADDR_PFX   = 8'h94;

    // The address is always a 20-byte string with a one-byte prefix.
    localparam int ADDR_BYTES   = 20;
    localparam int ADDR_ENC_LEN = ADDR_BYTES + 1;

    typedef struct packed {
        logic [63:0] list_index;
        logic [63:0] validator_number;
        logic [31:0] address_high;
        logic [63:0] address_mid;
        logic [63:0] address_low;
        logic [63:0] amount_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_item_t;

    // One integer after classification. A zero byte count means the
    // prefix byte is the whole encoding.
    typedef struct packed {
        logic [63:0] value;
        logic [7:0]  prefix;
        logic [3:0]  nbytes;
    } int_enc_t;

    // A classified record, as it waits in the queue.
    typedef struct packed {
        logic [7:0]   hdr;
        int_enc_t     idx;
        int_enc_t     val;
        logic [159:0] addr;
        int_enc_t     amt;
    } desc_t;

endpackage

// ----- rtl/withdrawal_rlp_encoder_top.sv -----
// Top level of the withdrawal RLP encoder: classifier, queue and serializer.
// Throughput: one beat per cycle while enc_ready is high and a record is queued;
// a record is 25 to 49 encoded bytes, one beat per byte from the serializer.
// Reset: rst_n clears the queue, the serializer state and the output valid flag at once.
module withdrawal_rlp_encoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    output logic               rec_ready,
    input  wre_pkg::in_item_t  rec,
    output logic               enc_valid,
    input  logic               enc_ready,
    output wre_pkg::out_item_t enc
);
    import wre_pkg::*;

    // The front end classifies a record in the cycle it is accepted: it finds the
    // minimal byte length of each integer, its prefix byte, and the list header.
    // The queue lets the front end take new records while the back end is still
    // streaming an earlier one. The back end walks the header, the two integers,
    // the address and the amount, one beat per cycle while the consumer takes them, and picks
    // up the next record on the same edge that sends the last beat of the current one, so
    // records follow each other without a gap when the next one is already queued.

    logic  push_valid;
    logic  push_ready;
    desc_t push_desc;
    logic  q_valid;
    logic  q_pop;
    desc_t q_desc;

    wre_front u_front (
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec        (rec),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    wre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_desc   (q_desc)
    );

    // The output register inside the back end parts the queue from the consumer.
    wre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_desc    (q_desc),
        .enc_valid (enc_valid),
        .enc_ready (enc_ready),
        .enc       (enc)
    );

endmodule

// ----- rtl/wre_front.sv -----
// Front end: classifies each record and computes its list header.
module wre_front (
    input  logic            rec_valid,
    output logic            rec_ready,
    input  wre_pkg::in_item_t rec,
    output logic            push_valid,
    input  logic            push_ready,
    output wre_pkg::desc_t  push_desc
);
    import wre_pkg::*;

    // Minimal big-endian form of one unsigned 64-bit integer.
    function automatic int_enc_t enc_u64(input logic [63:0] v);
        int_enc_t   e;
        logic [3:0] nb;
        nb = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[8*i +: 8] != 8'd0)
            begin
                nb = 4'(i + 1);
            end
        end
        e.value = v;
        if (v == 64'd0)
        begin
            e.prefix = RLP_SHORT_STR;
            e.nbytes = 4'd0;
        end
        else if (v < 64'h80)
        begin
            e.prefix = v[7:0];
            e.nbytes = 4'd0;
        end
        else
        begin
            e.prefix = RLP_SHORT_STR + {4'd0, nb};
            e.nbytes = nb;
        end
        return e;
    endfunction

    int_enc_t   idx_enc;
    int_enc_t   val_enc;
    int_enc_t   amt_enc;
    logic [5:0] payload_len;

    always_comb
    begin
        idx_enc = enc_u64(rec.list_index);
        val_enc = enc_u64(rec.validator_number);
        amt_enc = enc_u64(rec.amount_value);
        payload_len = 6'd3 + {2'd0, idx_enc.nbytes} + {2'd0, val_enc.nbytes}
                    + {2'd0, amt_enc.nbytes} + 6'(ADDR_ENC_LEN);
    end

    assign push_desc.hdr  = RLP_SHORT_LIST + {2'd0, payload_len};
    assign push_desc.idx  = idx_enc;
    assign push_desc.val  = val_enc;
    assign push_desc.addr = {rec.address_high, rec.address_mid, rec.address_low};
    assign push_desc.amt  = amt_enc;

    assign push_valid = rec_valid;
    assign rec_ready  = push_ready;

endmodule

// ----- rtl/wre_queue.sv -----
// Short register queue between the classifier and the serializer.
module wre_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  wre_pkg::desc_t push_desc,
    output logic           pop_valid,
    input  logic           pop_ready,
    output wre_pkg::desc_t pop_desc
);
    import wre_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    desc_t           slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

endmodule

// ----- rtl/wre_back.sv -----
// Back end: walks a classified record and emits its encoding byte by byte.
module wre_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  wre_pkg::desc_t     q_desc,
    output logic               enc_valid,
    input  logic               enc_ready,
    output wre_pkg::out_item_t enc
);
    import wre_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HDR  = 3'd1;
    localparam logic [2:0] ST_IDX  = 3'd2;
    localparam logic [2:0] ST_VAL  = 3'd3;
    localparam logic [2:0] ST_ADDR = 3'd4;
    localparam logic [2:0] ST_AMT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [4:0] cnt_reg;
    logic [4:0] cnt_next;
    desc_t      desc_reg;
    desc_t      desc_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_reg;
    out_item_t  out_next;

    logic       adv;
    logic       load;
    logic       emit;
    logic [7:0] byte_v;
    logic       last_v;
    int_enc_t   cur_int;
    logic [2:0] int_sel;
    logic [4:0] addr_sel;
    logic [63:0] int_shift;
    logic [159:0] addr_shift;

    assign adv      = !out_valid_reg || enc_ready;
    assign int_sel  = cnt_reg[2:0] - 3'd1;
    assign addr_sel = cnt_reg - 5'd1;

    always_comb
    begin
        case (state_reg)
            ST_IDX:  cur_int = desc_reg.idx;
            ST_VAL:  cur_int = desc_reg.val;
            default: cur_int = desc_reg.amt;
        endcase
        int_shift  = cur_int.value >> {int_sel, 3'b000};
        addr_shift = desc_reg.addr >> {addr_sel, 3'b000};
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        desc_next      = desc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        load           = 1'b0;
        emit           = 1'b0;
        byte_v         = 8'd0;
        last_v         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                load = q_valid;
            end
            ST_HDR:
            begin
                if (adv)
                begin
                    emit       = 1'b1;
                    byte_v     = desc_reg.hdr;
                    state_next = ST_IDX;
                    cnt_next   = 5'd0;
                end
            end
            ST_IDX, ST_VAL, ST_AMT:
            begin
                if (adv)
                begin
                    emit = 1'b1;
                    if (cnt_reg == 5'd0)
                    begin
                        byte_v   = cur_int.prefix;
                        cnt_next = {1'b0, cur_int.nbytes};
                    end
                    else
                    begin
                        byte_v   = int_shift[7:0];
                        cnt_next = cnt_reg - 5'd1;
                    end
                    // The field ends on its prefix when it has no data bytes.
                    if ((cnt_reg == 5'd0 && cur_int.nbytes == 4'd0) || cnt_reg == 5'd1)
                    begin
                        cnt_next = 5'd0;
                        case (state_reg)
                            ST_IDX:
                            begin
                                state_next = ST_VAL;
                            end
                            ST_VAL:
                            begin
                                state_next = ST_ADDR;
                            end
                            default:
                            begin
                                last_v     = 1'b1;
                                load       = q_valid;
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_ADDR:
            begin
                if (adv)
                begin
                    emit = 1'b1;
                    if (cnt_reg == 5'd0)
                    begin
                        byte_v   = RLP_ADDR_PFX;
                        cnt_next = 5'(ADDR_BYTES);
                    end
                    else
                    begin
                        byte_v   = addr_shift[7:0];
                        cnt_next = cnt_reg - 5'd1;
                        if (cnt_reg == 5'd1)
                        begin
                            cnt_next   = 5'd0;
                            state_next = ST_AMT;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            desc_next  = q_desc;
            state_next = ST_HDR;
        end

        if (adv)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            out_next.out_byte  = byte_v;
            out_next.last_byte = last_v;
        end
    end

    assign q_pop     = load;
    assign enc_valid = out_valid_reg;
    assign enc       = out_reg;

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_idle_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && out_valid_reg) |-> out_reg.last_byte)
        else $error("idle with a beat pending that is not the last");

    a_hdr_is_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (desc_reg.hdr[7:6] == 2'b11))
        else $error("record header is not a short list header");

    a_addr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADDR) |-> (cnt_reg <= 5'(ADDR_BYTES)))
        else $error("address byte count out of range");

endmodule
